// ===== design/etfp_pkg.sv =====
// Package for the escape-time fractal pixel core: shared types, constants and a 32-bit saturation function.
// No dependencies.
`default_nettype none
package etfp_pkg;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 32;
	localparam logic [CfgIdxW-1:0] REG_KIND = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_ZOOM = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_SHIFT_RE = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_SHIFT_IM = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_JULIA_RE = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_JULIA_IM = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_LIMIT = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_THRESH = 3'd7;
	localparam logic [23:0] COLOR_WHITE = 24'hFFFFFF;
	localparam logic [23:0] COLOR_BLACK = 24'h000000;
	localparam int unsigned MulW = 32;
	localparam int unsigned ProdW = 64;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_MAPRE = 10'b00_0000_0010,
		ST_MAPIM = 10'b00_0000_0100,
		ST_PLACE = 10'b00_0000_1000,
		ST_OFFS  = 10'b00_0001_0000,
		ST_ITER  = 10'b00_0010_0000,
		ST_STEP  = 10'b00_0100_0000,
		ST_MAG   = 10'b00_1000_0000,
		ST_COLOR = 10'b01_0000_0000,
		ST_OUT   = 10'b10_0000_0000
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage
`default_nettype wire

// ===== design/etfp_mul.sv =====
// Bit-serial 32x32 multiplier: one multiplier bit per cycle, shift-and-add.
// done pulses for one cycle once all multiplier bits have been processed; a new start restarts it.
// Depends on etfp_pkg.
`default_nettype none
module etfp_mul (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [etfp_pkg::MulW-1:0] a,
	input wire logic signed [etfp_pkg::MulW-1:0] b,
	output logic done,
	output logic signed [etfp_pkg::ProdW-1:0] prod
);
	import etfp_pkg::*;
	logic [4:0] cnt_q;
	logic busy_q;
	logic [ProdW-1:0] mag_a_q;
	logic [MulW-1:0] mag_b_q;
	logic neg_q;
	logic [ProdW-1:0] acc_q;
	logic [ProdW-1:0] acc_next;
	logic [ProdW-1:0] neg_acc;
	logic [MulW-1:0] abs_a;
	logic [MulW-1:0] abs_b;

	// Operands are made positive; while busy, a shifts left and b shifts right one bit per cycle.
	assign abs_a = a[MulW-1] ? (~a + MulW'(1)) : a;
	assign abs_b = b[MulW-1] ? (~b + MulW'(1)) : b;
	assign acc_next = mag_b_q[0] ? acc_q + mag_a_q : acc_q;
	assign neg_acc = ~acc_q + ProdW'(1);
	assign prod = neg_q ? neg_acc : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_a_q <= {{(ProdW-MulW){1'b0}}, abs_a};
			mag_b_q <= abs_b;
			neg_q <= a[MulW-1] ^ b[MulW-1];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_next;
			mag_a_q <= mag_a_q << 1;
			mag_b_q <= mag_b_q >> 1;
		end
	end
endmodule
`default_nettype wire

// ===== design/escape_time_fractal_pixel_core.sv =====
// Escape-time fractal pixel core: a pixel is mapped, placed, then z = z^2 + c is iterated.
// The time is set by two mapping divisions, bit-serial multiplies (two per iteration) and,
// on an escape, a color division; a zero limit skips the iterations.
// Throughput: one pixel at a time; the next is taken once the result transaction is done.
// Reset (arst_n low, asynchronous) restores the default registers and empties the core.
`default_nettype none
module escape_time_fractal_pixel_core #(
	parameter int unsigned IMAGE_WIDTH = 1024,
	parameter int unsigned IMAGE_HEIGHT = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [etfp_pkg::CfgIdxW-1:0] cfg_index,
	input wire logic [etfp_pkg::CfgDataW-1:0] cfg_data,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [23:0] s_tdata, // pixel_col[9:0], pixel_row[19:10], zero pad
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [47:0] m_tdata // out_col[9:0], out_row[19:10], color[43:20], escaped[44]
);
	import etfp_pkg::*;

	localparam logic [15:0] WIDTH_DIV = 16'(IMAGE_WIDTH);
	localparam logic [15:0] HEIGHT_DIV = 16'(IMAGE_HEIGHT);
	localparam logic signed [65:0] HALF_RANGE = 66'sd536870912;

	logic kind_q;
	logic [30:0] zoom_q;
	logic signed [31:0] shre_q, shim_q, jre_q, jim_q;
	logic [15:0] limit_q;
	logic [31:0] thresh_q;

	state_t state_q;
	logic [9:0] col_q, row_q;
	logic signed [31:0] zr_q, zi_q, cr_q, ci_q;
	logic [15:0] iter_q;
	logic [23:0] color_q;
	logic esc_q;
	logic mstart_q;
	logic signed [65:0] acc_q;

	logic mdone0, mdone1;
	logic signed [63:0] p0, p1;
	logic signed [65:0] fl0, fl1;
	logic [63:0] mag_sum;
	logic escape;

	// Two multipliers: lane 0 multiplies zr, lane 1 multiplies zi.
	logic signed [31:0] a0, b0, a1, b1;
	etfp_mul u_mul0 (.clk, .arst_n, .start(mstart_q), .a(a0), .b(b0), .done(mdone0), .prod(p0));
	etfp_mul u_mul1 (.clk, .arst_n, .start(mstart_q), .a(a1), .b(b1), .done(mdone1), .prod(p1));

	assign fl0 = $signed({{2{p0[63]}}, p0}) >>> 28;
	assign fl1 = $signed({{2{p1[63]}}, p1}) >>> 28;
	assign mag_sum = 64'(p0) + 64'(p1);
	assign escape = mag_sum[63:28] > {4'd0, thresh_q};

	always_comb begin
		a0 = zr_q; b0 = zr_q; a1 = zi_q; b1 = zi_q;
		case (state_q)
			ST_PLACE: begin
				b0 = $signed({1'b0, zoom_q});
				b1 = $signed({1'b0, zoom_q});
			end
			ST_STEP: begin
				b0 = zi_q;
			end
			default: ;
		endcase
	end

	// Shared restoring divider for the mapping and the color, one quotient bit a cycle.
	logic [39:0] num_q;
	logic [15:0] rem_q;
	logic [15:0] div_q;
	logic [5:0] dcnt_q;
	logic [16:0] rem_try;
	logic div_run, div_done;
	assign rem_try = {rem_q, num_q[39]} - {1'b0, div_q};
	assign div_done = (dcnt_q == 6'd40);
	assign div_run = (state_q inside {ST_MAPRE, ST_MAPIM, ST_COLOR}) && !div_done;

	assign s_tready = (state_q == ST_IDLE) && !m_tvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= 1'b0;
			zoom_q <= 31'h1000_0000;
			shre_q <= '0; shim_q <= '0; jre_q <= '0; jim_q <= '0;
			limit_q <= 16'd64;
			thresh_q <= 32'h4000_0000;
			state_q <= ST_IDLE;
			mstart_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KIND: kind_q <= cfg_data[0];
					REG_ZOOM: zoom_q <= cfg_data[30:0];
					REG_SHIFT_RE: shre_q <= cfg_data;
					REG_SHIFT_IM: shim_q <= cfg_data;
					REG_JULIA_RE: jre_q <= cfg_data;
					REG_JULIA_IM: jim_q <= cfg_data;
					REG_LIMIT: limit_q <= cfg_data[15:0];
					REG_THRESH: thresh_q <= cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			mstart_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_tvalid && s_tready) state_q <= ST_MAPRE;
				ST_MAPRE: if (div_done) state_q <= ST_MAPIM;
				ST_MAPIM: if (div_done) begin
					state_q <= ST_PLACE; mstart_q <= 1'b1;
				end
				ST_PLACE: if (mdone0) state_q <= ST_OFFS;
				ST_OFFS: if (limit_q == 16'd0) begin
					state_q <= ST_OUT;
				end else begin
					state_q <= ST_ITER; mstart_q <= 1'b1;
				end
				ST_ITER: if (mdone0) begin
					state_q <= ST_STEP; mstart_q <= 1'b1;
				end
				ST_STEP: if (mdone0) begin
					state_q <= ST_MAG; mstart_q <= 1'b1;
				end
				// The squares of the new z serve both the escape test and the next step.
				ST_MAG: if (mdone0) begin
					if (escape) begin
						state_q <= ST_COLOR;
					end else if (iter_q + 16'd1 == limit_q) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_STEP; mstart_q <= 1'b1;
					end
				end
				ST_COLOR: if (div_done) state_q <= ST_OUT;
				ST_OUT: begin
					m_tvalid <= 1'b1; state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (div_run) begin
			dcnt_q <= dcnt_q + 6'd1;
			num_q <= {num_q[38:0], !rem_try[16]};
			rem_q <= rem_try[16] ? {rem_q[14:0], num_q[39]} : rem_try[15:0];
		end
		case (state_q)
			ST_IDLE: if (s_tvalid && s_tready) begin
				col_q <= s_tdata[9:0]; row_q <= s_tdata[19:10];
				iter_q <= '0; esc_q <= 1'b0; color_q <= COLOR_WHITE;
				num_q <= {s_tdata[9:0], 30'd0}; div_q <= WIDTH_DIV;
				rem_q <= '0; dcnt_q <= '0;
			end
			ST_MAPRE: if (div_done) begin
				zr_q <= sat32($signed({26'd0, num_q}) - HALF_RANGE);
				num_q <= {row_q, 30'd0}; div_q <= HEIGHT_DIV;
				rem_q <= '0; dcnt_q <= '0;
			end
			ST_MAPIM: if (div_done) zi_q <= sat32(HALF_RANGE - $signed({26'd0, num_q}));
			ST_PLACE: if (mdone0) begin
				zr_q <= sat32(fl0); zi_q <= sat32(fl1);
			end
			ST_OFFS: begin
				zr_q <= sat32(66'(zr_q) + 66'(shre_q));
				zi_q <= sat32(66'(zi_q) + 66'(shim_q));
				cr_q <= kind_q ? jre_q : sat32(66'(zr_q) + 66'(shre_q));
				ci_q <= kind_q ? jim_q : sat32(66'(zi_q) + 66'(shim_q));
			end
			ST_ITER: if (mdone0) acc_q <= 66'(p0) - 66'(p1);
			ST_STEP: if (mdone0) begin
				zr_q <= sat32((acc_q >>> 28) + 66'(cr_q));
				zi_q <= sat32(($signed({{2{p0[63]}}, p0}) >>> 27) + 66'(ci_q));
			end
			ST_MAG: if (mdone0) begin
				if (escape) begin
					esc_q <= 1'b1;
					num_q <= ({24'd0, iter_q} << 24) - {24'd0, iter_q};
					div_q <= limit_q;
					rem_q <= '0; dcnt_q <= '0;
				end else begin
					iter_q <= iter_q + 16'd1;
					acc_q <= 66'(p0) - 66'(p1);
				end
			end
			ST_COLOR: if (div_done) color_q <= num_q[23:0] + COLOR_BLACK;
			ST_OUT: m_tdata <= {3'd0, esc_q, color_q, row_q, col_q};
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) m_tvalid |-> !s_tready)
		else $error("input taken while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |=> m_tvalid) else $error("result not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COLOR) |-> esc_q) else $error("color without escape");
	assert property (@(posedge clk) disable iff (!arst_n) mdone0 == mdone1)
		else $error("multiplier lanes out of step");
	assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state register not one-hot");
endmodule
`default_nettype wire
